@@ hdl/jms_pkg.sv @@
// Package for the JPEG marker segmenter: payload structs, phase and marker
// kind enums, marker constants and the marker classification table.
// No dependencies.
package jms_pkg;

  localparam int JMS_POS_W = 32;
  localparam int JMS_QUEUE_DEPTH = 4;

  localparam logic [7:0] MARK_FIRST = 8'hC0;
  localparam logic [7:0] MARK_PREFIX = 8'hFF;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } jms_in_t;

  typedef struct packed {
    logic [7:0]  marker_code;
    logic [31:0] segment_offset;
    logic [31:0] segment_size;
    logic        status;
    logic        last_of_run;
  } jms_out_t;

  typedef struct packed {
    logic     valid0;
    logic     valid1;
    jms_out_t res0;
    jms_out_t res1;
  } jms_emit_t;

  typedef enum logic [1:0] {
    PH_SCAN,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP
  } jms_phase_t;

  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_LENGTH,
    KIND_SCAN
  } jms_kind_t;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  function automatic jms_kind_t jms_marker_kind(input logic [7:0] m);
    jms_kind_t k;
    case (m) inside
      8'hD8, 8'hD9, [8'hD0:8'hD7]: k = KIND_FIXED;
      [8'hC0:8'hC3], [8'hC9:8'hCB], 8'hC4, 8'hCC, 8'hDA, 8'hDB, 8'hDC, 8'hDD,
      8'hFE, [8'hE0:8'hEF]: k = KIND_LENGTH;
      default: k = KIND_SCAN;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/jms_parser.sv @@
// Marker parser: stream state registers and the per-byte step that yields
// up to two results for each accepted byte. Depends on jms_pkg.
module jms_parser
  import jms_pkg::*;
#(
  parameter int POSITION_WIDTH = JMS_POS_W
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  jms_in_t   in_data,
  output jms_emit_t emit
);

  logic [POSITION_WIDTH-1:0] position, position_next;
  logic [POSITION_WIDTH-1:0] cur_offset, cur_offset_next;
  logic [POSITION_WIDTH-1:0] offs, run_size;
  logic                      prev_ff, prev_ff_next;
  jms_phase_t                phase, phase_next;
  logic [7:0]                len_hi, len_hi_next;
  logic [15:0]               skip, skip_next;
  logic [7:0]                cur_marker, cur_marker_next;
  logic                      open_seg, open_seg_next;
  logic [7:0]                b;
  logic [15:0]               len;
  jms_kind_t                 kind;
  jms_out_t                  r0, r1;
  logic                      e0, e1;

  function automatic jms_out_t make_result(input logic [7:0] code,
                                           input logic [31:0] off32,
                                           input logic [31:0] size32,
                                           input logic st);
    jms_out_t r;
    r.marker_code = code;
    r.segment_offset = off32;
    r.segment_size = size32;
    r.status = st;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign b = in_data.byte_value;
  assign len = {len_hi, b};
  assign kind = jms_marker_kind(b);
  assign offs = position + POSITION_WIDTH'(1);
  assign run_size = position - POSITION_WIDTH'(1) - cur_offset;

  always_comb begin
    position_next = offs;
    cur_offset_next = cur_offset;
    prev_ff_next = prev_ff;
    phase_next = phase;
    len_hi_next = len_hi;
    skip_next = skip;
    cur_marker_next = cur_marker;
    open_seg_next = open_seg;
    e0 = 1'b0;
    e1 = 1'b0;
    r0 = '0;
    r1 = '0;
    unique case (phase)
      PH_SCAN: begin
        if (prev_ff && b >= MARK_FIRST && b != MARK_PREFIX) begin
          if (open_seg) begin
            e0 = 1'b1;
            r0 = make_result(cur_marker, 32'(cur_offset), 32'(run_size), STATUS_FOUND);
            open_seg_next = 1'b0;
          end
          cur_marker_next = b;
          cur_offset_next = offs;
          prev_ff_next = 1'b0;
          unique case (kind)
            KIND_FIXED: begin
              if (open_seg) begin
                e1 = 1'b1;
                r1 = make_result(b, 32'(offs), 32'd0, STATUS_FOUND);
              end else begin
                e0 = 1'b1;
                r0 = make_result(b, 32'(offs), 32'd0, STATUS_FOUND);
              end
            end
            KIND_LENGTH: phase_next = PH_LEN_HI;
            default: open_seg_next = 1'b1;
          endcase
        end else begin
          prev_ff_next = (b == MARK_PREFIX);
        end
      end
      PH_LEN_HI: begin
        len_hi_next = b;
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        e0 = 1'b1;
        r0 = make_result(cur_marker, 32'(cur_offset), 32'(len), STATUS_FOUND);
        skip_next = (len >= 16'd2) ? len - 16'd2 : 16'd0;
        phase_next = (skip_next != 16'd0) ? PH_SKIP : PH_SCAN;
        prev_ff_next = 1'b0;
      end
      PH_SKIP: begin
        skip_next = (skip != 16'd0) ? skip - 16'd1 : 16'd0;
        if (skip_next == 16'd0) begin
          phase_next = PH_SCAN;
          prev_ff_next = 1'b0;
        end
      end
      default: phase_next = PH_SCAN;
    endcase
    if (in_data.last_byte) begin
      if (phase_next != PH_SCAN || open_seg_next) begin
        if (e0) begin
          e1 = 1'b1;
          r1 = make_result(8'd0, 32'(cur_offset_next), 32'd0, STATUS_TRUNC);
        end else begin
          e0 = 1'b1;
          r0 = make_result(8'd0, 32'(cur_offset_next), 32'd0, STATUS_TRUNC);
        end
      end
      position_next = '0;
      cur_offset_next = '0;
      prev_ff_next = 1'b0;
      phase_next = PH_SCAN;
      len_hi_next = '0;
      skip_next = '0;
      cur_marker_next = '0;
      open_seg_next = 1'b0;
    end
    r0.last_of_run = !e1;
    r1.last_of_run = 1'b1;
    emit.valid0 = e0;
    emit.valid1 = e1;
    emit.res0 = r0;
    emit.res1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      cur_offset <= '0;
      prev_ff <= 1'b0;
      phase <= PH_SCAN;
      len_hi <= '0;
      skip <= '0;
      cur_marker <= '0;
      open_seg <= 1'b0;
    end else if (fire) begin
      position <= position_next;
      cur_offset <= cur_offset_next;
      prev_ff <= prev_ff_next;
      phase <= phase_next;
      len_hi <= len_hi_next;
      skip <= skip_next;
      cur_marker <= cur_marker_next;
      open_seg <= open_seg_next;
    end
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip != 16'd0)
    else $error("skip phase with no payload left");

  a_open_only_scan: assert property (@(posedge clk) disable iff (rst)
    open_seg |-> phase == PH_SCAN)
    else $error("open segment outside scan phase");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    emit.valid1 |-> emit.valid0)
    else $error("second result without first");

endmodule

@@ hdl/jms_result_queue.sv @@
// Result queue: small register queue that takes up to two results per
// transaction and delivers one per ready cycle. Depends on jms_pkg.
module jms_result_queue
  import jms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  jms_emit_t emit,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output jms_out_t  out_data
);

  localparam int PtrW = $clog2(JMS_QUEUE_DEPTH);
  localparam int CntW = $clog2(JMS_QUEUE_DEPTH + 1);

  jms_out_t            entries [JMS_QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     count, count_next;
  logic [CntW-1:0]     wr_n;
  logic                pop;

  assign in_ready = (count <= CntW'(JMS_QUEUE_DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_data = entries[rd_ptr];
  assign pop = out_valid && out_ready;
  assign wr_n = fire ? (CntW'(emit.valid0) + CntW'(emit.valid1)) : '0;
  assign count_next = count + wr_n - CntW'(pop);

  always_ff @(posedge clk) begin
    if (fire && emit.valid0) begin
      entries[wr_ptr] <= emit.res0;
    end
    if (fire && emit.valid1) begin
      entries[wr_ptr + PtrW'(1)] <= emit.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(wr_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(JMS_QUEUE_DEPTH))
    else $error("result queue overflow");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (wr_n == '0 && !pop) |=> $stable(count))
    else $error("queue count moved without push or pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    PtrW'(wr_ptr - rd_ptr) == PtrW'(count))
    else $error("queue pointers disagree with count");

endmodule

@@ hdl/jpeg_marker_segmenter_unit.sv @@
// Top level of the JPEG marker segmenter: parser plus result queue.
// Depends on jms_pkg, jms_parser and jms_result_queue.
//
// Takes one stream byte per transaction and reports each marker segment as
// a result transaction: marker code, offset just past the marker, size, and
// a status that flags a stream ending inside an open segment. A byte is
// accepted every clock while the four-entry result queue has room for two
// results; results are registered in the queue and leave at one per clock
// while the output is ready. A byte that closes a segment and emits a fixed
// marker, or emits a result and ends the stream in an open segment, yields
// two results; under a continuously ready output the sustained rate is one
// byte per clock, and the queue's single read port holds the input back
// when results pile up. After a byte marked last the state returns to reset
// and the next byte starts a new stream at position zero.
module jpeg_marker_segmenter_unit
  import jms_pkg::*;
#(
  parameter int POSITION_WIDTH = JMS_POS_W
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  jms_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jms_out_t out_data
);

  jms_emit_t emit;
  logic      fire;

  assign fire = in_valid && in_ready;

  jms_parser #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .in_data(in_data),
    .emit   (emit)
  );

  jms_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .emit     (emit),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for jpeg_marker_segmenter_unit: a short stimulus table,
// then random JPEG-like streams checked against an in-bench segment predictor.
// Depends on jms_pkg and the jpeg_marker_segmenter_unit RTL.
module tb_top;
  import jms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [7:0] MK_SOF0 = 8'hC0;
  localparam logic [7:0] MK_DHT = 8'hC4;
  localparam logic [7:0] MK_JPG = 8'hC8;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_EOI = 8'hD9;
  localparam logic [7:0] MK_DQT = 8'hDB;
  localparam logic [7:0] MK_APP0 = 8'hE0;
  localparam logic [7:0] MK_JPG0 = 8'hF0;
  localparam logic [7:0] MK_COM = 8'hFE;
  localparam jms_out_t NO_SEG = '0;

  typedef struct packed {
    jms_in_t    data;
    logic       fixed_exp;
    logic [1:0] fixed_n;
    jms_out_t   fixed0;
    jms_out_t   fixed1;
  } stim_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  jms_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  jms_out_t out_data;

  stim_t    byte_plan[$];
  jms_out_t segments_due[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  int       bytes_taken = 0;
  int       next_idx = 0;
  int       cur_idx = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_left = 0;
  logic     draining = 1'b0;
  int       n_found;
  jms_out_t seg0;
  jms_out_t seg1;

  logic [31:0] scan_pos;
  logic        after_ff;
  jms_phase_t  parse_phase;
  logic [7:0]  len_high;
  logic [15:0] skip_left;
  logic [7:0]  open_marker;
  logic [31:0] open_offset;
  logic        seg_open;

  jpeg_marker_segmenter_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic jms_kind_t classify_marker(input logic [7:0] m);
    if (m == 8'hD8 || m == 8'hD9 || (m >= 8'hD0 && m <= 8'hD7)) return KIND_FIXED;
    if ((m >= 8'hC0 && m <= 8'hC4) || (m >= 8'hC9 && m <= 8'hCC) ||
        (m >= 8'hDA && m <= 8'hDD) || (m >= 8'hE0 && m <= 8'hEF) || m == 8'hFE)
      return KIND_LENGTH;
    return KIND_SCAN;
  endfunction

  function automatic jms_out_t seg_result(input logic [7:0] code, input logic [31:0] offs,
                                          input logic [31:0] size, input logic status,
                                          input logic last);
    seg_result = {code, offs, size, status, last};
  endfunction

  function automatic logic [7:0] pick_marker(input jms_kind_t kind);
    logic [7:0] m;
    m = 8'($urandom_range(8'hC0, 8'hFE));
    while (classify_marker(m) != kind) m = 8'($urandom_range(8'hC0, 8'hFE));
    return m;
  endfunction

  task automatic clear_parser();
    scan_pos = '0;
    after_ff = 1'b0;
    parse_phase = PH_SCAN;
    len_high = '0;
    skip_left = '0;
    open_marker = '0;
    open_offset = '0;
    seg_open = 1'b0;
  endtask

  task automatic predict_segments(input jms_in_t t, output int n, output jms_out_t r0,
                                  output jms_out_t r1);
    jms_out_t found[2];
    logic [7:0] b;
    logic [15:0] len;
    n = 0;
    found[0] = NO_SEG;
    found[1] = NO_SEG;
    b = t.byte_value;
    case (parse_phase)
      PH_SCAN: begin
        if (after_ff && b >= MARK_FIRST && b != MARK_PREFIX) begin
          if (seg_open) begin
            found[n] = seg_result(open_marker, open_offset, scan_pos - 32'd1 - open_offset,
                                  STATUS_FOUND, 1'b0);
            n++;
            seg_open = 1'b0;
          end
          open_marker = b;
          open_offset = scan_pos + 32'd1;
          after_ff = 1'b0;
          case (classify_marker(b))
            KIND_FIXED: begin
              found[n] = seg_result(b, scan_pos + 32'd1, 32'd0, STATUS_FOUND, 1'b0);
              n++;
            end
            KIND_LENGTH: parse_phase = PH_LEN_HI;
            default: seg_open = 1'b1;
          endcase
        end else begin
          after_ff = (b == MARK_PREFIX);
        end
      end
      PH_LEN_HI: begin
        len_high = b;
        parse_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len = {len_high, b};
        found[n] = seg_result(open_marker, open_offset, {16'h0, len}, STATUS_FOUND, 1'b0);
        n++;
        skip_left = (len >= 16'd2) ? len - 16'd2 : 16'd0;
        parse_phase = (skip_left != 16'd0) ? PH_SKIP : PH_SCAN;
        after_ff = 1'b0;
      end
      default: begin
        if (skip_left != 16'd0) skip_left--;
        if (skip_left == 16'd0) begin
          parse_phase = PH_SCAN;
          after_ff = 1'b0;
        end
      end
    endcase
    scan_pos = scan_pos + 32'd1;
    if (t.last_byte) begin
      if (parse_phase != PH_SCAN || seg_open) begin
        found[n] = seg_result(8'h00, open_offset, 32'd0, STATUS_TRUNC, 1'b0);
        n++;
      end
      clear_parser();
    end
    if (n > 0) found[n-1].last_of_run = 1'b1;
    r0 = found[0];
    r1 = found[1];
  endtask

  task automatic plan_byte(input logic [7:0] b, input logic last);
    stim_t s;
    s = '0;
    s.data.byte_value = b;
    s.data.last_byte = last;
    byte_plan.push_back(s);
  endtask

  task automatic add_row(input logic [7:0] b, input logic last, input logic [1:0] n,
                         input jms_out_t r0, input jms_out_t r1);
    stim_t s;
    s.data.byte_value = b;
    s.data.last_byte = last;
    s.fixed_exp = 1'b1;
    s.fixed_n = n;
    s.fixed0 = r0;
    s.fixed1 = r1;
    byte_plan.push_back(s);
  endtask

  task automatic plan_stream();
    logic [7:0] s[$];
    logic [7:0] v;
    logic [7:0] m;
    int target;
    int r;
    int len;
    int cut;
    target = $urandom_range(8, 120);
    if ($urandom_range(0, 3) == 0) begin
      v = 8'($urandom);
      s.push_back(v);
    end
    while (s.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        repeat ($urandom_range(1, 3)) s.push_back(MARK_PREFIX);
        v = 8'(MK_RST0 + $urandom_range(0, 9));
        s.push_back(v);
      end else if (r < 55) begin
        m = pick_marker(KIND_LENGTH);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
        s.push_back(MARK_PREFIX);
        s.push_back(m);
        s.push_back(len[15:8]);
        s.push_back(len[7:0]);
        for (int i = 2; i < len; i++) begin
          v = ($urandom_range(0, 3) == 0) ? MARK_PREFIX : 8'($urandom);
          s.push_back(v);
        end
      end else if (r < 75) begin
        m = pick_marker(KIND_SCAN);
        s.push_back(MARK_PREFIX);
        s.push_back(m);
        repeat ($urandom_range(0, 30)) begin
          v = ($urandom_range(0, 4) == 0) ? MARK_PREFIX : 8'($urandom);
          s.push_back(v);
          if (v == MARK_PREFIX && $urandom_range(0, 4) != 0) s.push_back(8'h00);
        end
      end else if (r < 90) begin
        repeat ($urandom_range(1, 8)) begin
          v = ($urandom_range(0, 2) == 0) ? MARK_PREFIX : 8'($urandom);
          s.push_back(v);
        end
      end else if ($urandom_range(0, 1) == 0) begin
        v = 8'($urandom);
        s.push_back(MARK_PREFIX);
        s.push_back(v);
      end else begin
        m = pick_marker(KIND_LENGTH);
        s.push_back(MARK_PREFIX);
        s.push_back(m);
        v = 8'($urandom_range(8'h80, 8'hFF));
        s.push_back(v);
        repeat ($urandom_range(1, 6)) begin
          v = 8'($urandom);
          s.push_back(v);
        end
        break;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, s.size());
      while (s.size() > cut) void'(s.pop_back());
    end
    for (int i = 0; i < s.size(); i++) plan_byte(s[i], i == s.size() - 1);
  endtask

  task automatic check_segment(input jms_out_t got);
    jms_out_t want;
    if (segments_due.size() == 0) begin
      $error("unexpected result: marker_code %h segment_offset %0d", got.marker_code,
             got.segment_offset);
      fail_count++;
    end else begin
      want = segments_due.pop_front();
      if (got.marker_code !== want.marker_code) begin
        $error("marker_code: expected %h, actual %h", want.marker_code, got.marker_code);
        fail_count++;
      end
      if (got.segment_offset !== want.segment_offset) begin
        $error("segment_offset: expected %0d, actual %0d", want.segment_offset,
               got.segment_offset);
        fail_count++;
      end
      if (got.segment_size !== want.segment_size) begin
        $error("segment_size: expected %0d, actual %0d", want.segment_size,
               got.segment_size);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %b, actual %b", want.status, got.status);
        fail_count++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %b, actual %b", want.last_of_run, got.last_of_run);
        fail_count++;
      end
    end
  endtask

  initial begin
    clear_parser();
    plan_byte(MARK_PREFIX, 1'b0);
    plan_byte(MK_APP0, 1'b0);
    plan_byte(8'h00, 1'b0);
    add_row(8'h04, 1'b0, 2'd1, seg_result(MK_APP0, 2, 4, STATUS_FOUND, 1'b1), NO_SEG);
    plan_byte(MARK_PREFIX, 1'b0);
    plan_byte(MK_EOI, 1'b0);
    plan_byte(MARK_PREFIX, 1'b0);
    plan_byte(MK_JPG, 1'b0);
    plan_byte(8'hBF, 1'b0);
    plan_byte(MARK_PREFIX, 1'b0);
    plan_byte(MARK_PREFIX, 1'b0);
    add_row(MK_RST0, 1'b0, 2'd2, seg_result(MK_JPG, 8, 2, STATUS_FOUND, 1'b0),
            seg_result(MK_RST0, 12, 0, STATUS_FOUND, 1'b1));
    plan_byte(MARK_PREFIX, 1'b0);
    plan_byte(MK_DQT, 1'b0);
    plan_byte(8'h00, 1'b0);
    add_row(8'h01, 1'b0, 2'd1, seg_result(MK_DQT, 14, 1, STATUS_FOUND, 1'b1), NO_SEG);
    plan_byte(MARK_PREFIX, 1'b0);
    plan_byte(MK_COM, 1'b0);
    plan_byte(8'h00, 1'b0);
    add_row(8'h03, 1'b0, 2'd1, seg_result(MK_COM, 18, 3, STATUS_FOUND, 1'b1), NO_SEG);
    plan_byte(MARK_PREFIX, 1'b0);
    plan_byte(MK_SOF0, 1'b0);
    plan_byte(MARK_PREFIX, 1'b0);
    plan_byte(MK_DHT, 1'b0);
    add_row(8'h00, 1'b1, 2'd1, seg_result(8'h00, 24, 0, STATUS_TRUNC, 1'b1), NO_SEG);
    plan_byte(MARK_PREFIX, 1'b0);
    add_row(MK_JPG0, 1'b1, 2'd1, seg_result(8'h00, 2, 0, STATUS_TRUNC, 1'b1), NO_SEG);
    begin
      int goal;
      goal = byte_plan.size() + RANDOM_BYTES;
      while (byte_plan.size() < goal) plan_stream();
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (!(bytes_taken == byte_plan.size() && segments_due.size() == 0) &&
           cycle_count < CYCLE_LIMIT)
      @(negedge clk);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      draining = 1'b1;
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (fail_count == 0 && segments_due.size() == 0)
        $display("tb: success");
      else
        $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      cycle_count++;

      if (in_valid && in_ready) begin
        predict_segments(byte_plan[cur_idx].data, n_found, seg0, seg1);
        if (byte_plan[cur_idx].fixed_exp) begin
          n_found = byte_plan[cur_idx].fixed_n;
          seg0 = byte_plan[cur_idx].fixed0;
          seg1 = byte_plan[cur_idx].fixed1;
        end
        if (n_found > 0) segments_due.push_back(seg0);
        if (n_found > 1) segments_due.push_back(seg1);
        bytes_taken++;
      end

      if (!in_valid || in_ready) begin
        if (next_idx < byte_plan.size() && gap_left == 0) begin
          in_valid <= 1'b1;
          in_data <= byte_plan[next_idx].data;
          cur_idx = next_idx;
          next_idx++;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end

      if (out_valid && out_ready) check_segment(out_data);

      if (draining) begin
        out_ready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        hold_left = $urandom_range(0, 7);
      end else begin
        out_ready <= 1'b1;
        hold_left = $urandom_range(0, 30);
      end
    end
  end

endmodule

@@ jpeg_marker_segmenter_unit.f @@
hdl/jms_pkg.sv
hdl/jms_parser.sv
hdl/jms_result_queue.sv
hdl/jpeg_marker_segmenter_unit.sv
tb/tb_top.sv
